/* rtl/sip24_pkg.sv */
// sip24_pkg: shared types, constants and helpers for the SipHash-2-4 unit.
// Used by sip24_round, sip24_core and siphash_2_4_keyed_hash_unit.
// No dependencies.
`timescale 1ns / 1ps

package sip24_pkg;

	localparam int WORD_W = 64;
	localparam int LEN_W  = 8;
	localparam int CNT_W  = 4;

	localparam int COMPRESS_ROUNDS = 2;
	localparam int FINAL_ROUNDS    = 4;
	localparam int MAX_ROUNDS      = (COMPRESS_ROUNDS > FINAL_ROUNDS) ?
		COMPRESS_ROUNDS : FINAL_ROUNDS;
	localparam int RC_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

	localparam logic [WORD_W-1:0] INIT_ZERO  = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] INIT_ONE   = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] INIT_TWO   = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] INIT_THREE = 64'h7465646279746573;
	localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

	localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic [WORD_W-1:0] v3;
	} lanes_t;

	typedef struct packed {
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
	} key_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
	                                           input int unsigned s);
		rotl = (x << s) | (x >> (WORD_W - s));
	endfunction

endpackage

/* rtl/sip24_round.sv */
// sip24_round: one SipRound over the four 64-bit lanes, combinational.
// Depends on sip24_pkg.
`timescale 1ns / 1ps

module sip24_round import sip24_pkg::*; (
	input  lanes_t lanes_i,
	output lanes_t lanes_o
);

	logic [WORD_W-1:0] a0, a1, a2, a3;
	logic [WORD_W-1:0] b0, b1, b2, b3;

	always_comb begin
		// first half: v0/v1 and v2/v3 pairs
		a0 = lanes_i.v0 + lanes_i.v1;
		a1 = rotl(lanes_i.v1, 13) ^ a0;
		a0 = rotl(a0, 32);
		a2 = lanes_i.v2 + lanes_i.v3;
		a3 = rotl(lanes_i.v3, 16) ^ a2;
		// second half: cross pairs
		b0 = a0 + a3;
		b3 = rotl(a3, 21) ^ b0;
		b2 = a2 + a1;
		b1 = rotl(a1, 17) ^ b2;
		b2 = rotl(b2, 32);
		lanes_o.v0 = b0;
		lanes_o.v1 = b1;
		lanes_o.v2 = b2;
		lanes_o.v3 = b3;
	end

endmodule

/* rtl/sip24_core.sv */
// sip24_core: lane registers, round sequencer and result register.
// Depends on sip24_pkg and sip24_round.
`timescale 1ns / 1ps

module sip24_core import sip24_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  key_t              key,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  logic [WORD_W-1:0] message_word,
	input  logic [CNT_W-1:0]  valid_bytes,
	input  logic              last_word,
	output logic              hash_valid,
	input  logic              hash_stall,
	output logic [WORD_W-1:0] hash_value
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [RC_W-1:0]   rc_q;
	logic              open_q;
	logic              fin_q;
	logic              need_tail_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] hash_q;

	lanes_t            lanes_q;
	logic [WORD_W-1:0] blk_q;
	logic [WORD_W-1:0] tail_q;
	logic [LEN_W-1:0]  len_q;

	lanes_t            rnd_in, rnd_out, absorbed, fin_lanes, init_lanes;
	logic              absorb_end, final_end, in_ready, accept;
	logic              out_take, slot_free, full_word, hash_load;
	logic [CNT_W-1:0]  cnt_sat;
	logic [LEN_W-1:0]  len_next;
	logic [WORD_W-1:0] masked, tail_word;
	logic [WORD_W-1:0] rnd_hash, lane_hash, hash_next;

	sip24_round u_round (
		.lanes_i (rnd_in),
		.lanes_o (rnd_out)
	);

	always_comb begin
		absorb_end = (state_q == ST_ABSORB) && (rc_q == RC_W'(COMPRESS_ROUNDS - 1));
		final_end  = (state_q == ST_FINAL) && (rc_q == RC_W'(FINAL_ROUNDS - 1));

		// message block enters v3 on the first round of an absorb
		rnd_in = lanes_q;
		if (state_q == ST_ABSORB && rc_q == '0) begin
			rnd_in.v3 = lanes_q.v3 ^ blk_q;
		end

		absorbed    = rnd_out;
		absorbed.v0 = rnd_out.v0 ^ blk_q;

		// tail absorbed: mark v2 before finalization
		fin_lanes    = absorbed;
		fin_lanes.v2 = absorbed.v2 ^ FINAL_MARK;

		init_lanes.v0 = INIT_ZERO ^ key.k0;
		init_lanes.v1 = INIT_ONE ^ key.k1;
		init_lanes.v2 = INIT_TWO ^ key.k0;
		init_lanes.v3 = INIT_THREE ^ key.k1;

		// next word may follow the last round of a non-final absorb
		in_ready  = (state_q == ST_IDLE) || (absorb_end && !fin_q);
		accept    = msg_valid && in_ready;
		out_take  = out_valid_q && !hash_stall;
		slot_free = !out_valid_q || out_take;

		cnt_sat   = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
		full_word = !last_word || (cnt_sat == FULL_BYTES);
		len_next  = (open_q ? len_q : '0) +
		            (last_word ? LEN_W'(cnt_sat) : LEN_W'(FULL_BYTES));
		for (int b = 0; b < 8; b++) begin
			masked[8*b +: 8] = (!full_word && (cnt_sat > CNT_W'(b))) ?
			                   message_word[8*b +: 8] : 8'h00;
		end
		tail_word = masked | {len_next, {(WORD_W-LEN_W){1'b0}}};

		rnd_hash  = rnd_out.v0 ^ rnd_out.v1 ^ rnd_out.v2 ^ rnd_out.v3;
		lane_hash = lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;

		// result register loads on the last final round or from the held lanes
		hash_load = slot_free && (final_end || (state_q == ST_DONE));
		hash_next = (state_q == ST_DONE) ? lane_hash : rnd_hash;
	end

	assign msg_stall  = !in_ready;
	assign hash_valid = out_valid_q;
	assign hash_value = hash_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rc_q        <= '0;
			open_q      <= 1'b0;
			fin_q       <= 1'b0;
			need_tail_q <= 1'b0;
			out_valid_q <= 1'b0;
			hash_q      <= '0;
		end else begin
			if (hash_load) begin
				hash_q      <= hash_next;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				state_q     <= ST_ABSORB;
				rc_q        <= '0;
				open_q      <= 1'b1;
				fin_q       <= last_word;
				need_tail_q <= last_word && full_word;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
					end
					ST_ABSORB: begin
						if (absorb_end) begin
							rc_q <= '0;
							if (need_tail_q) begin
								need_tail_q <= 1'b0;
							end else if (fin_q) begin
								state_q <= ST_FINAL;
								open_q  <= 1'b0;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							rc_q <= rc_q + 1'b1;
						end
					end
					ST_FINAL: begin
						if (final_end) begin
							rc_q <= '0;
							if (slot_free) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							rc_q <= rc_q + 1'b1;
						end
					end
					ST_DONE: begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// lane and block registers
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q  <= full_word ? message_word : tail_word;
			tail_q <= tail_word;
			len_q  <= len_next;
			if (state_q == ST_IDLE) begin
				if (!open_q) begin
					lanes_q <= init_lanes;
				end
			end else begin
				lanes_q <= absorbed;
			end
		end else begin
			unique case (state_q)
				ST_ABSORB: begin
					if (absorb_end) begin
						if (need_tail_q) begin
							lanes_q <= absorbed;
							blk_q   <= tail_q;
						end else if (fin_q) begin
							lanes_q <= fin_lanes;
						end else begin
							lanes_q <= absorbed;
						end
					end else begin
						lanes_q <= rnd_out;
					end
				end
				ST_FINAL: begin
					lanes_q <= rnd_out;
				end
				ST_IDLE, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/siphash_2_4_keyed_hash_unit.sv */
// siphash_2_4_keyed_hash_unit: top level of the keyed SipHash-2-4 unit.
// Holds the key registers and the config port; depends on sip24_pkg and sip24_core.
`timescale 1ns / 1ps

// Usage:
//  - Config: write key_low (index REG_KEY_LOW) and key_high (REG_KEY_HIGH)
//    with cfg_write/cfg_index/cfg_data while the unit is idle. A new key is
//    picked up at the next message start.
//  - Message channel: msg_valid/msg_stall, a transfer when valid and not
//    stalled. Each transfer is one little-endian 64-bit word; last_word
//    closes the message and valid_bytes (0..8, larger saturates to 8) says
//    how many low bytes of that word count. Earlier words are always full.
//  - Hash channel: hash_valid/hash_stall, one 64-bit hash per message.
//  - Timing: one SipRound per cycle on a single shared round unit. Each word
//    is absorbed in COMPRESS_ROUNDS rounds (2); the next word can be taken in
//    the last round of a non-last word. A last word is absorbed as a tail
//    block, or as a full block and a tail block if it holds 8 bytes; then
//    FINAL_ROUNDS (4) rounds produce the hash.
//  - msg_stall is high while rounds run, except in a non-last word's last round.
//    If the hash register is still stalled when the next hash completes, the unit
//    holds that hash in its lanes and keeps msg_stall high until the slot frees up.
//  - Reset clears the keys to zero, closes any open message and drops
//    hash_valid.

module siphash_2_4_keyed_hash_unit import sip24_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  logic [WORD_W-1:0]    message_word,
	input  logic [CNT_W-1:0]     valid_bytes,
	input  logic                 last_word,
	output logic                 hash_valid,
	input  logic                 hash_stall,
	output logic [WORD_W-1:0]    hash_value
);

	key_t key_q;

	// key registers, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_KEY_LOW) begin
				key_q.k0 <= cfg_data;
			end else if (cfg_index == REG_KEY_HIGH) begin
				key_q.k1 <= cfg_data;
			end
		end
	end

	sip24_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (key_q),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_word (message_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

	// a non-last word never produces a hash on its own
	a_no_hash_from_body: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall && !last_word && !hash_valid) |=> !hash_valid)
		else $error("hash appeared after a non-last word");

	// rounds always separate a transfer from a new hash
	a_no_instant_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall) |=> !$rose(hash_valid))
		else $error("hash raised right after a message transfer");

	// a fresh hash only comes from the busy finalization phase
	a_hash_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid) |-> $past(msg_stall))
		else $error("hash raised while the unit was idle");

endmodule

/* dv/tb_siphash_2_4_keyed_hash_unit.sv */
// tb_siphash_2_4_keyed_hash_unit: self-checking testbench for the keyed SipHash-2-4 unit.
// Streams messages with random gaps and stalls and checks every hash against a local predictor.
// Depends on sip24_pkg and siphash_2_4_keyed_hash_unit only.
`timescale 1ns / 1ps

module tb_siphash_2_4_keyed_hash_unit;
	import sip24_pkg::*;

	localparam int RANDOM_WORDS  = 640;
	localparam int DRAIN_CYCLES  = 12;
	localparam int TAIL_CYCLES   = 20;
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off for the backpressure phase
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  count;
		logic              last;
	} word_item_t;

	// DUT ports; the driven inputs are at known values from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_KEY_LOW;
	logic [WORD_W-1:0]    cfg_data     = '0;
	logic                 msg_valid    = 1'b0;
	logic                 msg_stall;
	logic [WORD_W-1:0]    message_word = '0;
	logic [CNT_W-1:0]     valid_bytes  = '0;
	logic                 last_word    = 1'b0;
	logic                 hash_valid;
	logic                 hash_stall   = 1'b0;
	logic [WORD_W-1:0]    hash_value;

	// predictor state: key copy, lanes, byte count, open-message flag
	logic [WORD_W-1:0] key_k0 = '0;
	logic [WORD_W-1:0] key_k1 = '0;
	lanes_t            hash_lanes = '0;
	logic [LEN_W-1:0]  byte_count = '0;
	bit                msg_open   = 1'b0;

	word_item_t        words_pending[$];
	logic [WORD_W-1:0] hashes_due[$];

	int words_queued   = 0;
	int words_accepted = 0;
	int errors         = 0;
	int cycle_count    = 0;

	// idle controls, set by the sequence on the falling edge
	bit sender_mode = 1'b0;
	bit recv_mode   = 1'b0;
	int hold_req    = 0;

	// driver / monitor scratch
	bit                offer_open;
	int                gap_left   = 0;
	int                stall_left = 0;
	int                hold_left  = 0;
	bit                stall_next;
	word_item_t        next_item;
	logic [WORD_W-1:0] due_hash;

	siphash_2_4_keyed_hash_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_word (message_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x,
	                                                  input int s);
		return (x << s) | (x >> (WORD_W - s));
	endfunction

	function automatic lanes_t sip_mix(input lanes_t s);
		s.v0 += s.v1;
		s.v1 = rotate_left(s.v1, 13);
		s.v1 ^= s.v0;
		s.v0 = rotate_left(s.v0, 32);
		s.v2 += s.v3;
		s.v3 = rotate_left(s.v3, 16);
		s.v3 ^= s.v2;
		s.v0 += s.v3;
		s.v3 = rotate_left(s.v3, 21);
		s.v3 ^= s.v0;
		s.v2 += s.v1;
		s.v1 = rotate_left(s.v1, 17);
		s.v1 ^= s.v2;
		s.v2 = rotate_left(s.v2, 32);
		return s;
	endfunction

	function automatic lanes_t fold_word(input lanes_t s, input logic [WORD_W-1:0] w);
		s.v3 ^= w;
		for (int r = 0; r < COMPRESS_ROUNDS; r++)
			s = sip_mix(s);
		s.v0 ^= w;
		return s;
	endfunction

	// Called once per accepted message transfer; pushes a hash when the message closes.
	task automatic predict_hash(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] count,
	                            input logic last);
		logic [WORD_W-1:0] tail;
		logic [CNT_W-1:0]  n;
		if (!msg_open) begin
			hash_lanes.v0 = INIT_ZERO ^ key_k0;
			hash_lanes.v1 = INIT_ONE ^ key_k1;
			hash_lanes.v2 = INIT_TWO ^ key_k0;
			hash_lanes.v3 = INIT_THREE ^ key_k1;
			byte_count = '0;
			msg_open = 1'b1;
		end
		if (!last) begin
			// earlier words are always full, valid_bytes ignored
			hash_lanes = fold_word(hash_lanes, word);
			byte_count = byte_count + 8'd8;
		end else begin
			n = (count > FULL_BYTES) ? FULL_BYTES : count;  // 9..15 saturates
			if (n == FULL_BYTES) begin
				hash_lanes = fold_word(hash_lanes, word);
				tail = '0;
			end else if (n == 0) begin
				tail = '0;
			end else begin
				tail = word & ((64'd1 << (8 * n)) - 64'd1);
			end
			byte_count = byte_count + LEN_W'(n);
			tail |= {byte_count, 56'd0};
			hash_lanes = fold_word(hash_lanes, tail);
			hash_lanes.v2 ^= FINAL_MARK;
			for (int r = 0; r < FINAL_ROUNDS; r++)
				hash_lanes = sip_mix(hash_lanes);
			hashes_due.push_back(hash_lanes.v0 ^ hash_lanes.v1 ^ hash_lanes.v2 ^ hash_lanes.v3);
			msg_open = 1'b0;
		end
	endtask

	// mostly no idle, some short, a few long
	function automatic int pick_idle(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 70)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers queued words; a transfer is predicted at the edge it happens
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			offer_open = msg_valid;
			if (msg_valid && !msg_stall) begin
				predict_hash(message_word, valid_bytes, last_word);
				words_accepted++;
				offer_open = 1'b0;
			end
			// payload only moves once the current offer is gone
			if (!offer_open) begin
				if (gap_left > 0) begin
					gap_left--;
					msg_valid <= 1'b0;
				end else if (words_pending.size() > 0) begin
					next_item = words_pending.pop_front();
					message_word <= next_item.word;
					valid_bytes  <= next_item.count;
					last_word    <= next_item.last;
					msg_valid    <= 1'b1;
					gap_left = pick_idle(sender_mode);
				end else begin
					msg_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each hash transfer, then picks the next stall value
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hash_valid && !hash_stall) begin
				if (hashes_due.size() == 0) begin
					$error("hash_value: no hash expected, got %h", hash_value);
					errors++;
				end else begin
					due_hash = hashes_due.pop_front();
					if (hash_value !== due_hash) begin
						$error("hash_value: expected %h, actual %h", due_hash, hash_value);
						errors++;
					end
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else begin
				stall_left = pick_idle(recv_mode);
				stall_next = (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
			hash_stall <= stall_next;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("siphash_2_4_keyed_hash_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------
	// Key write at the next edge; predictor picks it up at once (unit is idle here).
	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_KEY_LOW)
			key_k0 = val;
		else
			key_k1 = val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_item(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] count,
	                          input logic last);
		word_item_t it;
		it.word  = word;
		it.count = count;
		it.last  = last;
		words_pending.push_back(it);
		words_queued++;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return ALL_ONES;
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [WORD_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		else if (r == 1)
			return ALL_ONES;
		else
			return {$urandom, $urandom};
	endfunction

	// Well-formed message: full words with noise in valid_bytes, then a last word.
	// A few long ones push the byte count past 256.
	task automatic queue_message();
		int nwords;
		logic [CNT_W-1:0] tail_count;
		nwords = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 40) : $urandom_range(1, 6);
		tail_count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(9, 15)) :
			CNT_W'($urandom_range(0, 8));
		for (int i = 0; i < nwords - 1; i++)
			queue_item(pick_word(), CNT_W'($urandom_range(0, 15)), 1'b0);
		queue_item(pick_word(), tail_count, 1'b1);
	endtask

	// Sender pause: everything accepted, every hash back, then let the rounds settle.
	task automatic wait_drained();
		while (words_accepted != words_queued || hashes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : sequence_main
		int phase;
		int target;
		int base;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// empty message under the all-zero key
		write_key(REG_KEY_LOW, '0);
		write_key(REG_KEY_HIGH, '0);
		queue_item(pick_word(), 4'd0, 1'b1);
		wait_drained();

		// all-ones key: full last word, one byte, saturated count, ignored high bytes,
		// non-last word with junk count, two full words
		write_key(REG_KEY_LOW, ALL_ONES);
		write_key(REG_KEY_HIGH, ALL_ONES);
		queue_item(ALL_ONES, 4'd8, 1'b1);
		queue_item('0, 4'd1, 1'b1);
		queue_item(ALL_ONES, 4'd15, 1'b1);
		queue_item(ALL_ONES, 4'd7, 1'b1);
		queue_item(ALL_ONES, 4'd3, 1'b0);
		queue_item(pick_word(), 4'd4, 1'b1);
		queue_item(pick_word(), 4'd8, 1'b0);
		queue_item(pick_word(), 4'd8, 1'b1);
		wait_drained();

		// byte-sequence key over a 15-byte message
		write_key(REG_KEY_LOW, 64'h0706050403020100);
		write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		queue_item(64'h0706050403020100, 4'd0, 1'b0);
		queue_item(64'hff0e0d0c0b0a0908, 4'd7, 1'b1);
		wait_drained();

		// key change while a message is open: old lanes stay, new key on next message
		queue_item(ALL_ONES, 4'd0, 1'b0);
		queue_item('0, 4'd9, 1'b0);
		wait_drained();
		write_key(REG_KEY_LOW, {$urandom, $urandom});
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		queue_item(pick_word(), 4'd5, 1'b1);
		queue_item(pick_word(), 4'd2, 1'b1);
		wait_drained();

		// --- random phases ---
		base = words_queued;
		phase = 0;
		while (words_queued < base + RANDOM_WORDS) begin
			if ($urandom_range(0, 3) != 0)
				write_key(REG_KEY_LOW, pick_key());
			if ($urandom_range(0, 3) != 0)
				write_key(REG_KEY_HIGH, pick_key());
			sender_mode = ($urandom_range(0, 3) != 0);
			recv_mode   = ($urandom_range(0, 3) != 0);
			if (phase == 1) begin
				// receiver holds off while the sender streams: unit fills and stalls
				sender_mode = 1'b0;
				hold_req = HOLD_CYCLES;
			end
			target = words_queued + $urandom_range(40, 90);
			while (words_queued < target)
				queue_message();
			wait_drained();
			phase++;
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && hashes_due.size() == 0)
			$display("siphash_2_4_keyed_hash_unit regression: pass");
		else
			$display("siphash_2_4_keyed_hash_unit regression: fail");
		$finish;
	end

endmodule
